@@ sv/crc_pkg.sv @@
// Package with shared types and constants of the color ramp interpolator.
package crc_pkg;

    localparam int MAX_KEYS  = 8;
    localparam int ADDR_W    = $clog2(MAX_KEYS);
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);
    localparam int TIME_W    = 17;
    localparam int COLOR_W   = 32;
    localparam int DVD_W     = 33;
    localparam int DIV_STEPS = 33;
    localparam int STEP_W    = 6;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        CMD_EVAL  = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [TIME_W-1:0]  key_time;
        logic [COLOR_W-1:0] color;
    } t_key;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [TIME_W-1:0] divisor;
    } t_div_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FRAC,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_FDIV,
        S_MUL,
        S_ACC,
        S_SCALE,
        S_DIV255,
        S_ADD_RD,
        S_ADD_CMP,
        S_ADD_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS,
        S_DONE
    } t_state;

endpackage

@@ sv/crc_key_ram.sv @@
// Key table memory: one write port, one registered read port.
module crc_key_ram
    import crc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_we,
    input  t_addr i_waddr,
    input  t_key  i_wdata,
    input  t_addr i_raddr,
    output t_key  o_rdata
);

    t_key r_mem [MAX_KEYS];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/crc_divider.sv @@
// Restoring divider, one quotient bit per cycle, 17-bit quotient kept.
module crc_divider
    import crc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [TIME_W-1:0] o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [TIME_W-1:0] r_rem;
    logic [DVD_W-1:0]  r_dvd;
    logic [TIME_W-1:0] r_dvs;
    logic [TIME_W-1:0] r_q;
    logic [TIME_W:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_q   <= {r_q[TIME_W-2:0], fits};
            if (fits) begin
                r_rem <= TIME_W'(trial - {1'b0, r_dvs});
            end else begin
                r_rem <= trial[TIME_W-1:0];
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

@@ sv/color_ramp_interpolator_core.sv @@
// Top level of the color ramp interpolator: sequencer, key table and datapath.
//
// Input channel (i_valid / o_stall) takes one request: evaluate, add key or
// clear table. Output channel (o_valid / i_stall) returns exactly one result
// per request. The color mode register is written on i_cfg_valid; o_cfg_ready
// is always high; writes must be made only while the block is idle, which the
// block does not enforce. One request is worked on at a time; o_stall is high
// from acceptance until its result is loaded into the output register.
// Work per request: clear goes straight to the result; add scans the keys and
// moves later keys up; evaluate scans the keys, runs up to two divisions in the
// shared serial divider (life fraction, then blend factor) and then works on
// each color channel in turn.
// A finished result waits in the output register while i_stall is high; the
// next request is still accepted, and its own result waits in the sequencer
// until the output register frees.
// Reset (i_rst_n low, synchronous) empties the key table, sets color mode 0
// and drops any pending result.
module color_ramp_interpolator_core
    import crc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_total_life,
    input  logic [15:0] i_remaining_life,
    input  logic [16:0] i_key_time,
    input  logic [7:0]  i_in_red,
    input  logic [7:0]  i_in_green,
    input  logic [7:0]  i_in_blue,
    input  logic [7:0]  i_in_alpha,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_color_written,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [7:0]  o_out_alpha,
    output logic        o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    t_state             r_state, n_state;
    t_cnt               r_count;
    t_addr              r_idx;
    t_cnt               r_pos;
    logic               r_mode;
    logic [TIME_W-1:0]  r_time;
    logic [COLOR_W-1:0] r_orig;
    logic [TIME_W-1:0]  r_frac;
    t_key               r_prev;
    logic [COLOR_W-1:0] r_c1, r_c2;
    logic [TIME_W-1:0]  r_f;
    logic [1:0]         r_k;
    logic [24:0]        r_p1, r_p2;
    logic [7:0]         r_ch;
    logic [15:0]        r_prod;
    logic [COLOR_W-1:0] r_res;
    logic               r_written;
    logic               r_status;
    logic               r_out_valid;
    logic               r_out_written;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_status;

    logic               ram_we;
    t_addr              ram_waddr, ram_raddr;
    t_key               ram_wdata, rd;
    t_div_req           div_req;
    logic               div_done;
    logic [TIME_W-1:0]  div_q;
    logic [15:0]        life_diff;
    logic               scan_last;
    logic               load_out;
    logic [25:0]        acc_sum;
    logic [16:0]        prod_rnd;
    logic [16:0]        d255;
    logic [7:0]         c1k, c2k, origk;

    crc_key_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    crc_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign life_diff = i_total_life - i_remaining_life;
    assign scan_last = ({1'b0, r_idx} + CNT_W'(1)) == r_count;
    assign c1k       = r_c1[8*r_k +: 8];
    assign c2k       = r_c2[8*r_k +: 8];
    assign origk     = r_orig[8*r_k +: 8];
    assign acc_sum   = {1'b0, r_p1} + {1'b0, r_p2} + 26'd32768;
    assign prod_rnd  = {1'b0, r_prod} + 17'd127;
    assign d255      = (prod_rnd + 17'd1 + {9'd0, prod_rnd[15:8]}) >> 8;
    assign load_out  = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        ram_we           = 1'b0;
        ram_waddr        = r_idx;
        ram_wdata        = '{key_time: r_time, color: r_orig};
        ram_raddr        = r_idx;
        div_req.start    = 1'b0;
        div_req.dividend = {r_frac - r_prev.key_time, 16'h0};
        div_req.divisor  = rd.key_time - r_prev.key_time;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (t_cmd'(i_cmd))
                        CMD_EVAL: begin
                            if (r_count == '0) begin
                                n_state = S_DONE;
                            end else if (i_total_life == '0
                                         || i_remaining_life > i_total_life) begin
                                n_state = S_SCAN_RD;
                            end else begin
                                div_req.start    = 1'b1;
                                div_req.dividend = {1'b0, life_diff, 16'h0};
                                div_req.divisor  = {1'b0, i_total_life};
                                n_state          = S_FRAC;
                            end
                        end
                        CMD_ADD: begin
                            n_state = (r_count == '0) ? S_ADD_CHK : S_ADD_RD;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_FRAC: begin
                if (div_done) begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (r_frac < rd.key_time) begin
                    if (r_idx == '0) begin
                        n_state = S_MUL;
                    end else begin
                        div_req.start = 1'b1;
                        n_state       = S_FDIV;
                    end
                end else if (scan_last) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_FDIV: begin
                if (div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_ACC;
            S_ACC: begin
                if (r_mode) begin
                    n_state = S_SCALE;
                end else begin
                    n_state = (r_k == 2'd3) ? S_DONE : S_MUL;
                end
            end
            S_SCALE: n_state = S_DIV255;
            S_DIV255: n_state = (r_k == 2'd3) ? S_DONE : S_MUL;
            S_ADD_RD: n_state = S_ADD_CMP;
            S_ADD_CMP: begin
                if (rd.key_time == r_time) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{key_time: rd.key_time, color: r_orig};
                    n_state   = S_DONE;
                end else if (rd.key_time > r_time || scan_last) begin
                    n_state = S_ADD_CHK;
                end else begin
                    n_state = S_ADD_RD;
                end
            end
            S_ADD_CHK: begin
                if (r_count >= CNT_W'(MAX_KEYS)) begin
                    n_state = S_DONE;
                end else if (r_pos == r_count) begin
                    n_state = S_INS;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                ram_raddr = r_idx - 1'b1;
                n_state   = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_wdata = rd;
                n_state   = ({1'b0, r_idx - 1'b1} == r_pos) ? S_INS : S_SHIFT_RD;
            end
            S_INS: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[ADDR_W-1:0];
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mode  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (r_state == S_IDLE && i_valid && t_cmd'(i_cmd) == CMD_CLEAR) begin
                r_count <= '0;
            end else if (r_state == S_INS) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx     <= '0;
                r_pos     <= r_count;
                r_k       <= '0;
                r_time    <= i_key_time;
                r_orig    <= {i_in_alpha, i_in_blue, i_in_green, i_in_red};
                r_res     <= '0;
                r_written <= 1'b0;
                r_status  <= 1'b0;
                r_f       <= '0;
                r_frac    <= (i_total_life == '0) ? 17'h10000 : '0;
            end
            S_FRAC: begin
                if (div_done) begin
                    r_frac <= div_q;
                end
            end
            S_SCAN_CMP: begin
                r_written <= 1'b1;
                if (r_frac < rd.key_time) begin
                    r_c2 <= rd.color;
                    r_c1 <= (r_idx == '0) ? rd.color : r_prev.color;
                end else begin
                    r_prev <= rd;
                    r_idx  <= r_idx + 1'b1;
                    r_c1   <= rd.color;
                    r_c2   <= rd.color;
                end
            end
            S_FDIV: begin
                if (div_done) begin
                    r_f <= div_q;
                end
            end
            S_MUL: begin
                r_p1 <= c1k * (17'h10000 - r_f);
                r_p2 <= c2k * r_f;
            end
            S_ACC: begin
                r_ch <= (acc_sum[25:16] > 10'd255) ? 8'hFF : acc_sum[23:16];
                if (!r_mode) begin
                    r_res[8*r_k +: 8] <= (acc_sum[25:16] > 10'd255) ? 8'hFF
                                                                    : acc_sum[23:16];
                    r_k <= r_k + 1'b1;
                end
            end
            S_SCALE: r_prod <= r_ch * origk;
            S_DIV255: begin
                r_res[8*r_k +: 8] <= d255[7:0];
                r_k <= r_k + 1'b1;
            end
            S_ADD_CMP: begin
                if (rd.key_time != r_time) begin
                    if (rd.key_time > r_time) begin
                        r_pos <= {1'b0, r_idx};
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
            end
            S_ADD_CHK: begin
                r_idx    <= r_count[ADDR_W-1:0];
                r_status <= (r_count >= CNT_W'(MAX_KEYS));
            end
            S_SHIFT_WR: r_idx <= r_idx - 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_written <= r_written;
            r_out_color   <= r_res;
            r_out_status  <= r_status;
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_color_written = r_out_written;
    assign o_out_red       = r_out_color[7:0];
    assign o_out_green     = r_out_color[15:8];
    assign o_out_blue      = r_out_color[23:16];
    assign o_out_alpha     = r_out_color[31:24];
    assign o_status        = r_out_status;

endmodule

@@ dv/tb_top.sv @@
// Testbench for the color ramp interpolator core: queued driver, monitor and predictor.
`timescale 1ns / 1ps
module tb_top
    import crc_pkg::*;
();

    typedef struct {
        t_cmd        cmd;
        logic [15:0] total;
        logic [15:0] remain;
        logic [16:0] ktime;
        logic [7:0]  rgba [4];
    } t_request;

    typedef struct {
        logic       written;
        logic [7:0] rgba [4];
        logic       status;
    } t_color_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_cmd;
    logic [15:0] i_total_life;
    logic [15:0] i_remaining_life;
    logic [16:0] i_key_time;
    logic [7:0]  i_in_red;
    logic [7:0]  i_in_green;
    logic [7:0]  i_in_blue;
    logic [7:0]  i_in_alpha;
    logic        o_valid;
    logic        i_stall;
    logic        o_color_written;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic [7:0]  o_out_alpha;
    logic        o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;

    color_ramp_interpolator_core DUT (.*);

    t_request      pending_requests[$];
    t_color_result expected_colors[$];
    logic [16:0]   ramp_times [MAX_KEYS];
    logic [7:0]    ramp_colors [MAX_KEYS][4];
    int            ramp_count;
    logic          mode;
    int            errors;
    int            accepted_count;
    int            result_count;
    int            eval_count;
    int            full_count;
    int            idle_cycles;
    int            send_wait;
    int            recv_wait;
    int            hold_off;
    bit            hold_request;
    bit            done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_color_result predict_color(t_request r);
        t_color_result res;
        logic [16:0] frac;
        logic [16:0] f;
        logic [16:0] t1;
        logic [63:0] acc;
        int idx;
        int lo;
        int hi;
        res.written = 1'b0;
        res.status = 1'b0;
        for (int k = 0; k < 4; k++) res.rgba[k] = 8'd0;
        case (r.cmd)
            CMD_CLEAR: ramp_count = 0;
            CMD_ADD: begin
                idx = ramp_count;
                for (int i = 0; i < ramp_count; i++) begin
                    if (ramp_times[i] == r.ktime) begin
                        ramp_colors[i] = r.rgba;
                        return res;
                    end
                    if (ramp_times[i] > r.ktime) begin
                        idx = i;
                        break;
                    end
                end
                if (ramp_count >= MAX_KEYS) begin
                    res.status = 1'b1;
                    return res;
                end
                for (int i = ramp_count; i > idx; i--) begin
                    ramp_times[i] = ramp_times[i-1];
                    ramp_colors[i] = ramp_colors[i-1];
                end
                ramp_times[idx] = r.ktime;
                ramp_colors[idx] = r.rgba;
                ramp_count++;
            end
            CMD_EVAL: begin
                if (ramp_count == 0) return res;
                if (r.total == 0) frac = 17'd65536;
                else if (r.remain > r.total) frac = 17'd0;
                else frac = 17'(({16'd0, r.total - r.remain} << 16) / r.total);
                idx = ramp_count;
                for (int i = 0; i < ramp_count; i++) begin
                    if (frac < ramp_times[i]) begin
                        idx = i;
                        break;
                    end
                end
                f = 0;
                if (idx == 0) begin
                    lo = 0;
                    hi = 0;
                end else if (idx >= ramp_count) begin
                    lo = ramp_count - 1;
                    hi = lo;
                end else begin
                    lo = idx - 1;
                    hi = idx;
                    t1 = ramp_times[lo];
                    f = 17'(({47'd0, frac - t1} << 16) / (ramp_times[hi] - t1));
                end
                res.written = 1'b1;
                for (int k = 0; k < 4; k++) begin
                    acc = 64'(ramp_colors[lo][k]) * (64'd65536 - f)
                        + 64'(ramp_colors[hi][k]) * f + 64'd32768;
                    acc = acc >> 16;
                    if (acc > 255) acc = 255;
                    if (mode) acc = (acc * r.rgba[k] + 127) / 255;
                    res.rgba[k] = acc[7:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_request make_request(t_cmd c, int total, int remain, int kt,
                                              logic [31:0] col);
        t_request r;
        r.cmd = c;
        r.total = 16'(total);
        r.remain = 16'(remain);
        r.ktime = 17'(kt);
        for (int k = 0; k < 4; k++) r.rgba[k] = col[8*k +: 8];
        return r;
    endfunction

    function automatic t_request random_request();
        int pick;
        int kt;
        logic [31:0] col;
        t_cmd c;
        pick = $urandom_range(0, 99);
        col = $urandom;
        case ($urandom_range(0, 4))
            0: kt = 0;
            1: kt = 65536;
            2: kt = $urandom_range(65537, 131071);
            default: kt = $urandom_range(0, 65536);
        endcase
        if (pick < 60) c = CMD_EVAL;
        else if (pick < 90) c = CMD_ADD;
        else if (pick < 96) c = CMD_CLEAR;
        else c = CMD_NONE;
        return make_request(c, $urandom_range(0, 65535), $urandom_range(0, 65535), kt, col);
    endfunction

    task automatic run_phase();
        wait (pending_requests.size() == 0 && expected_colors.size() == 0);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_mode(logic m);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mode = m;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        mode = 1'b0;
        ramp_count = 0;
        errors = 0;
        hold_request = 1'b0;
        done = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        pending_requests.push_back(make_request(CMD_EVAL, 100, 50, 0, 32'hFFFFFFFF));
        pending_requests.push_back(make_request(CMD_ADD, 0, 0, 16384, 32'h00000000));
        pending_requests.push_back(make_request(CMD_EVAL, 100, 100, 0, 32'hFFFFFFFF));
        pending_requests.push_back(make_request(CMD_ADD, 0, 0, 49152, 32'hFFFFFFFF));
        pending_requests.push_back(make_request(CMD_ADD, 0, 0, 131071, 32'h80402010));
        pending_requests.push_back(make_request(CMD_EVAL, 0, 0, 0, 32'h12345678));
        pending_requests.push_back(make_request(CMD_EVAL, 65535, 0, 0, 32'h0));
        pending_requests.push_back(make_request(CMD_EVAL, 10, 65535, 0, 32'h0));
        pending_requests.push_back(make_request(CMD_EVAL, 4, 2, 0, 32'h0));
        pending_requests.push_back(make_request(CMD_EVAL, 4, 1, 0, 32'h0));
        pending_requests.push_back(make_request(CMD_ADD, 0, 0, 49152, 32'h11223344));
        for (int i = 0; i < 6; i++)
            pending_requests.push_back(make_request(CMD_ADD, 0, 0, 1000 * (i + 1), $urandom));
        pending_requests.push_back(make_request(CMD_ADD, 0, 0, 65536, 32'hFFFFFFFF));
        pending_requests.push_back(make_request(CMD_EVAL, 7, 3, 0, 32'hAA55AA55));
        pending_requests.push_back(make_request(CMD_NONE, 65535, 65535, 131071, 32'hFFFFFFFF));
        pending_requests.push_back(make_request(CMD_CLEAR, 0, 0, 0, 32'h0));
        pending_requests.push_back(make_request(CMD_EVAL, 3, 1, 0, 32'h0));
        run_phase();
        for (int p = 0; p < 6; p++) begin
            write_mode(p % 2 == 0);
            if (p == 2) hold_request = 1'b1;
            for (int i = 0; i < 300; i++) pending_requests.push_back(random_request());
            run_phase();
        end
        $display("covered %0d requests, %0d evaluations, %0d dropped keys, both color modes",
                 accepted_count, eval_count, full_count);
        done = 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_cmd <= CMD_NONE;
            i_total_life <= '0;
            i_remaining_life <= '0;
            i_key_time <= '0;
            {i_in_red, i_in_green, i_in_blue, i_in_alpha} <= '0;
            send_wait <= 0;
        end else if (i_valid && !o_stall) begin
            expected_colors.push_back(predict_color(pending_requests.pop_front()));
            accepted_count <= accepted_count + 1;
            i_valid <= 1'b0;
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        end else if (!i_valid && send_wait > 0) begin
            send_wait <= send_wait - 1;
        end else if (!i_valid && pending_requests.size() > 0) begin
            i_valid <= 1'b1;
            i_cmd <= pending_requests[0].cmd;
            i_total_life <= pending_requests[0].total;
            i_remaining_life <= pending_requests[0].remain;
            i_key_time <= pending_requests[0].ktime;
            i_in_red <= pending_requests[0].rgba[0];
            i_in_green <= pending_requests[0].rgba[1];
            i_in_blue <= pending_requests[0].rgba[2];
            i_in_alpha <= pending_requests[0].rgba[3];
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_wait <= 0;
            hold_off <= 0;
        end else if (hold_request) begin
            hold_request <= 1'b0;
            hold_off <= 400;
            i_stall <= 1'b1;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= (hold_off > 1);
        end else if (o_valid && !i_stall) begin
            recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            i_stall <= 1'b1;
        end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            i_stall <= (recv_wait > 1);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_color_result exp_c;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count <= result_count + 1;
            if (expected_colors.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                exp_c = expected_colors.pop_front();
                if (exp_c.written) eval_count++;
                if (exp_c.status) full_count++;
                if (o_color_written !== exp_c.written) begin
                    $error("color_written exp %0d got %0d", exp_c.written, o_color_written);
                    errors++;
                end
                if (o_out_red !== exp_c.rgba[0]) begin
                    $error("out_red exp %0d got %0d", exp_c.rgba[0], o_out_red);
                    errors++;
                end
                if (o_out_green !== exp_c.rgba[1]) begin
                    $error("out_green exp %0d got %0d", exp_c.rgba[1], o_out_green);
                    errors++;
                end
                if (o_out_blue !== exp_c.rgba[2]) begin
                    $error("out_blue exp %0d got %0d", exp_c.rgba[2], o_out_blue);
                    errors++;
                end
                if (o_out_alpha !== exp_c.rgba[3]) begin
                    $error("out_alpha exp %0d got %0d", exp_c.rgba[3], o_out_alpha);
                    errors++;
                end
                if (o_status !== exp_c.status) begin
                    $error("status exp %0d got %0d", exp_c.status, o_status);
                    errors++;
                end
            end
        end
    end

    initial begin
        accepted_count = 0;
        result_count = 0;
        eval_count = 0;
        full_count = 0;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (done) begin
                if (errors == 0 && expected_colors.size() == 0) $display("== PASS ==");
                else $display("== FAIL ==");
                $finish;
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 5000) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule

@@ sim.f @@
sv/crc_pkg.sv
sv/crc_key_ram.sv
sv/crc_divider.sv
sv/color_ramp_interpolator_core.sv
dv/tb_top.sv
